// ===== hw/rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and character codes for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam logic [7:0] LimitReset = 8'd64;
  localparam int unsigned MaxRecs   = 4;

  localparam logic RegLineLimit = 1'b0;

  typedef enum logic [2:0] {
    MODE_START = 3'b001,
    MODE_GAP   = 3'b010,
    MODE_ARG   = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ARG   = 2'd1,
    KIND_LINE  = 2'd2
  } kind_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] write_index;
    logic [7:0] args_seen;
  } clt_state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] buf_index;
    logic [7:0] buf_byte;
    logic [6:0] arg_number;
    logic [7:0] arg_count;
    logic       truncated;
  } clt_rec_t;

  typedef struct packed {
    clt_rec_t [MaxRecs-1:0] recs;
    logic [2:0]             count;
    clt_state_t             next;
  } clt_dec_t;

endpackage

// ===== hw/rtl/clt_decode.sv =====
// ----------------------------------------------------------------------------
// clt_decode
// Per-byte decode: result records and next parser state for one rx byte.
// ----------------------------------------------------------------------------
module clt_decode (
  input  clt_pkg::clt_state_t state_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          line_limit_i,
  output clt_pkg::clt_dec_t   dec_o
);
  import clt_pkg::*;

  logic       eol;
  logic       is_space;
  logic       do_arg;
  logic       do_write;
  logic       do_end;
  logic       wrap;
  logic [7:0] wr_val;
  logic [7:0] wi_inc;
  logic [7:0] args_cur;
  logic [2:0] n;

  always_comb begin
    eol      = (rx_byte_i == ChCr) || (rx_byte_i == ChLf);
    is_space = (rx_byte_i == ChSpace);
    do_arg   = 1'b0;
    do_write = 1'b0;
    do_end   = 1'b0;
    wr_val   = rx_byte_i;
    dec_o    = '0;
    dec_o.next = state_i;

    case (state_i.mode)
      MODE_ARG: begin
        if (eol) begin
          do_end = 1'b1;
        end else if (is_space) begin
          dec_o.next.mode = MODE_GAP;
          do_write        = 1'b1;
          wr_val          = ChNul;
        end else begin
          do_write = 1'b1;
        end
      end
      default: begin
        if (eol) begin
          if (state_i.mode == MODE_GAP) begin
            do_end = 1'b1;
          end else begin
            dec_o.next.mode = MODE_START;
          end
        end else if (is_space) begin
          dec_o.next.mode = MODE_GAP;
        end else begin
          do_arg          = 1'b1;
          do_write        = 1'b1;
          dec_o.next.mode = MODE_ARG;
        end
      end
    endcase

    args_cur = do_arg ? state_i.args_seen + 8'd1 : state_i.args_seen;
    wi_inc   = state_i.write_index + 8'd1;
    wrap     = do_write && (wi_inc == line_limit_i);

    dec_o.next.args_seen = args_cur;
    if (do_write) begin
      dec_o.next.write_index = wi_inc;
    end
    if (do_end || wrap) begin
      dec_o.next.mode        = MODE_START;
      dec_o.next.write_index = 8'd0;
      dec_o.next.args_seen   = 8'd0;
    end

    n = 3'd0;
    if (do_arg) begin
      dec_o.recs[n[1:0]].kind       = KIND_ARG;
      dec_o.recs[n[1:0]].buf_index  = state_i.write_index;
      dec_o.recs[n[1:0]].arg_number = state_i.args_seen[6:0];
      n = n + 3'd1;
    end
    if (do_write) begin
      dec_o.recs[n[1:0]].kind      = KIND_WRITE;
      dec_o.recs[n[1:0]].buf_index = state_i.write_index;
      dec_o.recs[n[1:0]].buf_byte  = wr_val;
      n = n + 3'd1;
    end
    if (do_end || wrap) begin
      dec_o.recs[n[1:0]].kind      = KIND_WRITE;
      dec_o.recs[n[1:0]].buf_index = state_i.write_index;
      dec_o.recs[n[1:0]].buf_byte  = ChNul;
      n = n + 3'd1;
      dec_o.recs[n[1:0]].kind      = KIND_LINE;
      dec_o.recs[n[1:0]].arg_count = args_cur;
      dec_o.recs[n[1:0]].truncated = wrap;
      n = n + 3'd1;
    end
    dec_o.count = n;
  end

endmodule

// ===== hw/rtl/command_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Splits received bytes into lines of space-separated arguments and reports
// buffer writes, argument starts and line completion as a record stream.
//
//   channel  dir  handshake            payload
//   s_axis   in   tvalid/tready        tdata: rx_byte
//   m_axis   out  tvalid/tready/tlast  tuser: kind, tdata: record fields
//   apb      in   psel/penable/pready  reg 0 at 0x0: line_limit
//
// a byte is decoded in the cycle it is accepted; its records (up to four)
// are held in a record register and leave one per cycle unless m_axis stalls.
// one byte per cycle while each byte yields at most one record and m_axis does
// not stall; a byte with more records holds off s_axis until all are taken.
// the next byte is taken in the cycle the last pending record is taken.
// reset returns to line start with line_limit = 64.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // rx_byte [7:0]
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // buf_index [7:0], buf_byte [15:8], arg_number [22:16], arg_count [30:23],
  // truncated [31]
  output logic [31:0] m_axis_tdata,
  // kind [1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clt_pkg::*;

  clt_state_t             state_q, state_d;
  logic [7:0]             limit_q, limit_d;
  clt_rec_t [MaxRecs-1:0] recs_q, recs_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [1:0]             ptr_q, ptr_d;
  logic                   pend_q, pend_d;
  clt_dec_t               dec;
  clt_rec_t               cur;
  logic                   take;
  logic                   is_last;
  logic                   accept;

  clt_decode u_decode (
    .state_i      (state_q),
    .rx_byte_i    (s_axis_tdata),
    .line_limit_i (limit_q),
    .dec_o        (dec)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLineLimit) ? {24'd0, limit_q} : 32'd0;

  assign cur     = recs_q[ptr_q];
  assign is_last = ({1'b0, ptr_q} == (cnt_q - 3'd1));
  assign take    = pend_q && m_axis_tready;
  assign s_axis_tready = !pend_q || (take && is_last);
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = pend_q;
  assign m_axis_tlast  = is_last;
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tdata  = {cur.truncated, cur.arg_count, cur.arg_number,
                          cur.buf_byte, cur.buf_index};

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && pready && (paddr[2] == RegLineLimit)) begin
      limit_d = pwdata[7:0];
    end
  end

  always_comb begin
    state_d = state_q;
    recs_d  = recs_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    pend_d  = pend_q;
    if (accept) begin
      state_d = dec.next;
      recs_d  = dec.recs;
      cnt_d   = dec.count;
      ptr_d   = 2'd0;
      pend_d  = (dec.count != 3'd0);
    end else if (take) begin
      if (is_last) begin
        pend_d = 1'b0;
      end else begin
        ptr_d = ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_START, write_index: 8'd0, args_seen: 8'd0};
      limit_q <= LimitReset;
      cnt_q   <= 3'd0;
      ptr_q   <= 2'd0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    recs_q <= recs_d;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the command line tokenizer and checks every
// output record (buffer writes, argument starts, line completions) against a
// cycle-free model of the line parser kept in a small scoreboard. Runs a
// short directed sequence, then random lines and noise under several line
// limits, with random stalls on both streams and APB writes between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam logic [2:0] LineLimitAddr = 3'({RegLineLimit, 2'b00});

  typedef struct {
    kind_e      kind;
    logic [7:0] buf_index;
    logic [7:0] buf_byte;
    logic [6:0] arg_number;
    logic [7:0] arg_count;
    logic       truncated;
    logic       last;
  } token_rec_t;

  class token_scoreboard;
    mode_e      mode;
    logic [7:0] write_index;
    logic [7:0] args_seen;
    logic [7:0] line_limit;
    token_rec_t record_q[$];
    int         errors;

    function new();
      line_limit = LimitReset;
      errors = 0;
      restart();
    endfunction

    function void restart();
      mode = MODE_START;
      write_index = 8'd0;
      args_seen = 8'd0;
    endfunction

    function void add(kind_e kind, logic [7:0] idx, logic [7:0] val,
                       logic [6:0] argn, logic [7:0] cnt, logic trunc);
      token_rec_t r;
      r.kind = kind;
      r.buf_index = idx;
      r.buf_byte = val;
      r.arg_number = argn;
      r.arg_count = cnt;
      r.truncated = trunc;
      r.last = 1'b0;
      record_q.push_back(r);
    endfunction

    function void close_line();
      add(KIND_WRITE, write_index, ChNul, 7'd0, 8'd0, 1'b0);
      add(KIND_LINE, 8'd0, ChNul, 7'd0, args_seen, 1'b0);
      restart();
    endfunction

    // buffer write; a line that hits the limit loses its last byte
    function void store(logic [7:0] val);
      add(KIND_WRITE, write_index, val, 7'd0, 8'd0, 1'b0);
      write_index = write_index + 8'd1;
      if (write_index == line_limit) begin
        write_index = write_index - 8'd1;
        add(KIND_WRITE, write_index, ChNul, 7'd0, 8'd0, 1'b0);
        add(KIND_LINE, 8'd0, ChNul, 7'd0, args_seen, 1'b1);
        restart();
      end
    endfunction

    // returns the number of records the byte causes
    function int note_byte(logic [7:0] rx);
      int         n;
      logic       eol;
      token_rec_t r;
      n = record_q.size();
      eol = (rx == ChCr) || (rx == ChLf);
      if (mode == MODE_ARG) begin
        if (eol) begin
          close_line();
        end else if (rx == ChSpace) begin
          mode = MODE_GAP;
          store(ChNul);
        end else begin
          store(rx);
        end
      end else if (eol) begin
        if (mode == MODE_GAP) begin
          close_line();
        end else begin
          mode = MODE_START;
        end
      end else if (rx == ChSpace) begin
        mode = MODE_GAP;
      end else begin
        add(KIND_ARG, write_index, ChNul, args_seen[6:0], 8'd0, 1'b0);
        args_seen = args_seen + 8'd1;
        mode = MODE_ARG;
        store(rx);
      end
      n = record_q.size() - n;
      if (n > 0) begin
        r = record_q.pop_back();
        r.last = 1'b1;
        record_q.push_back(r);
      end
      return n;
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_record(logic [1:0] kind, logic [31:0] data, logic last);
      token_rec_t e;
      if (record_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: record with none expected, expected nothing, actual kind %0d data %h",
                   $time, kind, data);
      end else begin
        e = record_q.pop_front();
        compare("kind", e.kind, kind);
        compare("buf_index", e.buf_index, data[7:0]);
        compare("buf_byte", e.buf_byte, data[15:8]);
        compare("arg_number", e.arg_number, data[22:16]);
        compare("arg_count", e.arg_count, data[30:23]);
        compare("truncated", e.truncated, data[31]);
        compare("last", e.last, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  token_scoreboard sb;
  bit steady = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int answered = 0;

  logic [7:0] opening[$] = '{ChCr, ChLf, ChSpace, ChCr, ChLf, "a", 8'hFF, ChSpace,
                             ChSpace, 8'h00, 8'h7F, ChLf, "b", ChSpace, ChCr, "c",
                             ChCr, ChLf, 8'h80, 8'h01, ChSpace, "d", ChSpace, "e",
                             ChLf};
  logic [7:0] cut_line[$] = '{"a", "b", "c", "d", ChSpace, ChCr};
  logic [7:0] limits[$] = '{8'd1, 8'd255, 8'd7, 8'd0, 8'd64, 8'd3, 8'd128, 8'd20};

  command_line_tokenizer_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_record(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  task automatic put_byte(input logic [7:0] rx);
    if (!steady && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tdata <= rx;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sb.note_byte(rx) > 0) answered++;
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    if ($urandom_range(0, 9) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChSpace || c == ChCr || c == ChLf);
    end
    return c;
  endfunction

  task automatic send_line();
    int words;
    words = $urandom_range(0, 6);
    repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? ChCr : ChLf);
    if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) put_byte(ChSpace);
    for (int w = 0; w < words; w++) begin
      repeat ($urandom_range(1, 8)) put_byte(text_char());
      if (w != words - 1 || $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) put_byte(ChSpace);
    end
    case ($urandom_range(0, 2))
      0: put_byte(ChCr);
      1: put_byte(ChLf);
      default: begin
        put_byte(ChCr);
        put_byte(ChLf);
      end
    endcase
  endtask

  task automatic random_part(input int target);
    answered = 0;
    while (answered < target) begin
      if ($urandom_range(0, 99) < 12) put_byte(8'($urandom_range(0, 255)));
      else send_line();
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.record_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LineLimitAddr;
    pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.line_limit = val;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) put_byte(opening[i]);
    drain();
    repeat (4) @(posedge clk_i);
    write_limit(8'd2);
    foreach (cut_line[i]) put_byte(cut_line[i]);

    foreach (limits[i]) begin
      drain();
      repeat (4) @(posedge clk_i);
      write_limit(limits[i]);
      steady = (i == 2);
      if (i == 4) hold_request = 90;
      if (i == 5) begin
        random_part(10);
        drain();
        random_part(12);
      end else begin
        random_part(22);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.record_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
